FILE: hdl/asxu_pkg.sv
package asxu_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned REG_COUNT = 16;
    localparam int unsigned REG_IDX_W = 4;

    localparam logic [REG_IDX_W-1:0] PC_IDX      = 4'd15;
    localparam logic [XLEN-1:0]      PC_STEP     = 32'd4;
    localparam logic [11:0]          IMM_MASK    = 12'hfff;

    typedef logic [XLEN-1:0]      word_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    typedef enum logic [1:0] {
        FMT_DATA   = 2'd0,
        FMT_MEM    = 2'd1,
        FMT_BRANCH = 2'd2,
        FMT_EXIT   = 2'd3
    } fmt_t;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } alu_op_t;

    typedef enum logic [3:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14,
        COND_NV = 4'd15
    } cond_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        word_t    next_pc;
        logic     cond_passed;
        logic     halted;
        logic     reg_written;
        reg_idx_t reg_index;
        word_t    reg_value;
        logic [3:0] flags_out;
    } result_t;

    typedef struct packed {
        word_t  result;
        flags_t flags;
        logic   is_test;
    } alu_out_t;

    function automatic logic cond_holds(input cond_t c, input flags_t f);
        logic ok;
        case (c)
            COND_EQ: ok = f.z;
            COND_NE: ok = !f.z;
            COND_CS: ok = f.c;
            COND_CC: ok = !f.c;
            COND_MI: ok = f.n;
            COND_PL: ok = !f.n;
            COND_VS: ok = f.v;
            COND_VC: ok = !f.v;
            COND_HI: ok = f.c && !f.z;
            COND_LS: ok = !f.c || f.z;
            COND_GE: ok = (f.n == f.v);
            COND_LT: ok = (f.n != f.v);
            COND_GT: ok = !f.z && (f.n == f.v);
            COND_LE: ok = f.z || (f.n != f.v);
            COND_AL: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

FILE: hdl/asxu_stream_if.sv
interface asxu_stream_if #(
    parameter type payload_t = logic [31:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/arm_subset_execute_unit.sv
// Executes a subset of a 32-bit ARM-style instruction set, one instruction word per item,
// against a 16-entry register file (entry 15 is the program counter), the NZCV flags and a
// halt mark, all zero after reset. Each item yields one result item with the new PC, whether
// the condition passed, the halt mark, the register write-back and the flags. An item passes
// through the operand stage, where the register file is read with bypass from the write of
// the item ahead, and then the execute stage, which updates state and loads the result
// register; a new item is taken every cycle while the result side keeps up. Once an
// exit instruction has run, later items change nothing and report halted.
module arm_subset_execute_unit (
    input  logic clk,
    input  logic rst_n,
    asxu_stream_if.sink   instr_ch,
    asxu_stream_if.source result_ch
);
    import asxu_pkg::*;

    // operand stage
    logic     s1_valid_reg;
    logic     s1_valid_next;
    word_t    s1_word_reg;
    word_t    mem_a_reg;
    word_t    mem_b_reg;
    logic     a_live_reg;
    logic     b_live_reg;
    logic     byp_a_reg;
    logic     byp_b_reg;
    word_t    byp_val_reg;

    // architectural state
    word_t    rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [REG_COUNT-1:0] rf_valid_next;
    word_t    pc_reg;
    word_t    pc_next;
    flags_t   flags_reg;
    flags_t   flags_next;
    logic     halt_reg;
    logic     halt_next;

    // result stage
    logic     res_valid_reg;
    logic     res_valid_next;
    result_t  res_reg;
    result_t  res_next;

    logic     instr_fire;
    logic     exec_fire;
    reg_idx_t rn_in;
    reg_idx_t rm_in;

    fmt_t     fmt;
    cond_t    cond;
    alu_op_t  op;
    logic     set_flags;
    logic     imm_sel;
    reg_idx_t rn;
    reg_idx_t rd;
    reg_idx_t rm;
    word_t    pc_plus4;
    word_t    opnd_a;
    word_t    opnd_b;
    word_t    rf_a;
    word_t    rf_b;
    word_t    branch_off;
    logic     passed;
    logic     wr;
    logic     rf_we;
    alu_out_t alu_out;

    assign exec_fire  = s1_valid_reg && (!res_valid_reg || result_ch.ready);
    assign instr_ch.ready = !s1_valid_reg || exec_fire;
    assign instr_fire = instr_ch.valid && instr_ch.ready;
    assign rn_in      = instr_ch.data[19:16];
    assign rm_in      = instr_ch.data[3:0];

    assign cond      = cond_t'(s1_word_reg[31:28]);
    assign fmt       = fmt_t'(s1_word_reg[27:26]);
    assign imm_sel   = s1_word_reg[25];
    assign op        = alu_op_t'(s1_word_reg[24:21]);
    assign set_flags = s1_word_reg[20];
    assign rn        = s1_word_reg[19:16];
    assign rd        = s1_word_reg[15:12];
    assign rm        = s1_word_reg[3:0];

    assign pc_plus4 = pc_reg + PC_STEP;
    assign rf_a = byp_a_reg ? byp_val_reg : (a_live_reg ? mem_a_reg : '0);
    assign rf_b = byp_b_reg ? byp_val_reg : (b_live_reg ? mem_b_reg : '0);
    assign opnd_a = (rn == PC_IDX) ? pc_plus4 : rf_a;
    assign opnd_b = imm_sel ? {20'd0, s1_word_reg[11:0] & IMM_MASK}
                  : ((rm == PC_IDX) ? pc_plus4 : rf_b);
    assign branch_off = {{6{s1_word_reg[23]}}, s1_word_reg[23:0], 2'b00};

    asxu_alu u_alu (
        .op       (op),
        .a        (opnd_a),
        .b        (opnd_b),
        .flags_in (flags_reg),
        .alu_out  (alu_out)
    );

    assign passed = !halt_reg && cond_holds(cond, flags_reg);
    assign wr     = passed && (fmt == FMT_DATA) && !alu_out.is_test;
    assign rf_we  = exec_fire && wr && (rd != PC_IDX);

    always_comb
    begin
        if (halt_reg)
        begin
            pc_next = pc_reg;
        end
        else if (wr && (rd == PC_IDX))
        begin
            pc_next = alu_out.result;
        end
        else if (passed && (fmt == FMT_BRANCH))
        begin
            pc_next = pc_plus4 + branch_off;
        end
        else
        begin
            pc_next = pc_plus4;
        end
    end

    always_comb
    begin
        flags_next = flags_reg;
        if (passed && (fmt == FMT_DATA) && (set_flags || alu_out.is_test))
        begin
            flags_next = alu_out.flags;
        end
        halt_next = halt_reg || (passed && (fmt == FMT_EXIT));
        rf_valid_next = rf_valid_reg;
        if (rf_we)
        begin
            rf_valid_next[rd] = 1'b1;
        end
    end

    always_comb
    begin
        res_next.next_pc     = pc_next;
        res_next.cond_passed = passed;
        res_next.halted      = halt_next;
        res_next.reg_written = wr;
        res_next.reg_index   = wr ? rd : '0;
        res_next.reg_value   = wr ? alu_out.result : '0;
        res_next.flags_out   = flags_next;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (instr_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (exec_fire)
        begin
            s1_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (exec_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // register file storage
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rd] <= alu_out.result;
        end
        if (instr_fire)
        begin
            mem_a_reg <= rf_mem[rn_in];
            mem_b_reg <= rf_mem[rm_in];
        end
    end

    // operand stage payload and bypass
    always_ff @(posedge clk)
    begin
        if (instr_fire)
        begin
            s1_word_reg <= instr_ch.data;
            a_live_reg  <= rf_valid_reg[rn_in];
            b_live_reg  <= rf_valid_reg[rm_in];
            byp_a_reg   <= rf_we && (rd == rn_in);
            byp_b_reg   <= rf_we && (rd == rm_in);
            byp_val_reg <= alu_out.result;
        end
        if (exec_fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
            pc_reg        <= '0;
            flags_reg     <= '0;
            halt_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (exec_fire)
            begin
                rf_valid_reg <= rf_valid_next;
                pc_reg       <= pc_next;
                flags_reg    <= flags_next;
                halt_reg     <= halt_next;
            end
        end
    end

    assign result_ch.valid = res_valid_reg;
    assign result_ch.data  = res_reg;

endmodule

FILE: hdl/asxu_alu.sv
module asxu_alu (
    input  asxu_pkg::alu_op_t  op,
    input  asxu_pkg::word_t    a,
    input  asxu_pkg::word_t    b,
    input  asxu_pkg::flags_t   flags_in,
    output asxu_pkg::alu_out_t alu_out
);
    import asxu_pkg::*;

    word_t       add_x;
    word_t       add_y;
    logic        add_cin;
    logic [XLEN:0] add_sum;
    word_t       add_r;
    logic        add_v;
    logic        is_arith;
    word_t       r;

    always_comb
    begin
        add_x    = a;
        add_y    = b;
        add_cin  = 1'b0;
        is_arith = 1'b1;
        case (op)
            OP_SUB, OP_CMP:
            begin
                add_y   = ~b;
                add_cin = 1'b1;
            end
            OP_RSB:
            begin
                add_x   = b;
                add_y   = ~a;
                add_cin = 1'b1;
            end
            OP_ADD, OP_CMN: add_cin = 1'b0;
            OP_ADC: add_cin = flags_in.c;
            OP_SBC:
            begin
                add_y   = ~b;
                add_cin = flags_in.c;
            end
            OP_RSC:
            begin
                add_x   = b;
                add_y   = ~a;
                add_cin = flags_in.c;
            end
            default: is_arith = 1'b0;
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{XLEN{1'b0}}, add_cin};
    assign add_r   = add_sum[XLEN-1:0];
    assign add_v   = ((add_x[XLEN-1] ^ add_r[XLEN-1]) & (add_y[XLEN-1] ^ add_r[XLEN-1]));

    always_comb
    begin
        case (op)
            OP_AND, OP_TST: r = a & b;
            OP_EOR, OP_TEQ: r = a ^ b;
            OP_ORR:         r = a | b;
            OP_MOV:         r = b;
            OP_BIC:         r = a & ~b;
            OP_MVN:         r = ~b;
            default:        r = add_r;
        endcase
    end

    always_comb
    begin
        alu_out.result  = r;
        alu_out.flags.n = r[XLEN-1];
        alu_out.flags.z = (r == '0);
        alu_out.flags.c = is_arith ? add_sum[XLEN] : flags_in.c;
        alu_out.flags.v = is_arith ? add_v : flags_in.v;
        alu_out.is_test = (op == OP_TST) || (op == OP_TEQ) || (op == OP_CMP) || (op == OP_CMN);
    end

endmodule
